// ===== rtl/skt_pkg.sv =====
// Package with the shared types, constants and round functions of the SKINNY-128 tweakey schedule.
package skt_pkg;

	localparam int unsigned MAX_ROUNDS  = 56;
	localparam int unsigned HALF_W      = 64;
	localparam int unsigned ROUND_W     = 6;
	localparam int unsigned RC_W        = 6;
	localparam int unsigned WORDS_W     = 2;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 6;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_TWEAKEY_WORDS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT   = 1'd1;

	localparam logic [ROUND_W-1:0] MAX_ROUNDS_CODE = ROUND_W'(MAX_ROUNDS);
	localparam logic [WORDS_W-1:0] WORDS_RESET     = 2'd3;
	localparam logic [RC_W-1:0]    RC_FIRST        = 6'h01;

	// One input word: the three tweakey words, each as two 64-bit halves.
	typedef struct packed {
		logic [HALF_W-1:0] tk1_low;
		logic [HALF_W-1:0] tk1_high;
		logic [HALF_W-1:0] tk2_low;
		logic [HALF_W-1:0] tk2_high;
		logic [HALF_W-1:0] tk3_low;
		logic [HALF_W-1:0] tk3_high;
	} in_t;

	// One result word.
	typedef struct packed {
		logic [HALF_W-1:0]  round_tweakey;
		logic [ROUND_W-1:0] round_number;
		logic               last;
	} out_t;

	// A running 128-bit tweakey word.
	typedef struct packed {
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
	} tk_word_t;

	// Sequencer outputs that steer the datapath.
	typedef struct packed {
		logic               run;
		logic               last;
		logic [ROUND_W-1:0] round;
		logic [RC_W-1:0]    rc;
	} ctrl_t;

	// Cell permutation P: the old low half moves up whole, and the new low half
	// takes the old high cells in the order 9, 15, 8, 13, 10, 14, 12, 11.
	function automatic tk_word_t permute_word(input tk_word_t w);
		tk_word_t r;
		r.hi = w.lo;
		r.lo = {w.hi[31:24], w.hi[39:32], w.hi[55:48], w.hi[23:16],
			w.hi[47:40], w.hi[7:0], w.hi[63:56], w.hi[15:8]};
		return r;
	endfunction

	function automatic logic [HALF_W-1:0] lfsr2_bytes(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] r;
		logic [7:0]        b;
		r = '0;
		for (int i = 0; i < HALF_W / 8; i++) begin
			b = x[8*i +: 8];
			r[8*i +: 8] = {b[6:0], b[7] ^ b[5]};
		end
		return r;
	endfunction

	function automatic logic [HALF_W-1:0] lfsr3_bytes(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] r;
		logic [7:0]        b;
		r = '0;
		for (int i = 0; i < HALF_W / 8; i++) begin
			b = x[8*i +: 8];
			r[8*i +: 8] = {b[0] ^ b[6], b[7:1]};
		end
		return r;
	endfunction

	function automatic logic [RC_W-1:0] step_constant(input logic [RC_W-1:0] rc);
		return {rc[4:0], ~(rc[5] ^ rc[4])};
	endfunction

endpackage

// ===== rtl/skt_round_unit.sv =====
// Shared round unit: forms the round tweakey and the next state of all three words.
module skt_round_unit (
	input  skt_pkg::tk_word_t          w1,
	input  skt_pkg::tk_word_t          w2,
	input  skt_pkg::tk_word_t          w3,
	input  logic [skt_pkg::RC_W-1:0]   rc,
	output skt_pkg::tk_word_t          w1_next,
	output skt_pkg::tk_word_t          w2_next,
	output skt_pkg::tk_word_t          w3_next,
	output logic [skt_pkg::HALF_W-1:0] round_tweakey
);
	import skt_pkg::*;

	tk_word_t p2;
	tk_word_t p3;
	logic [HALF_W-1:0] const_add;

	// c0 goes into the low nibble of byte 0, c1 into the low bits of byte 4.
	assign const_add = {30'd0, rc[5:4], 28'd0, rc[3:0]};
	assign round_tweakey = w1.lo ^ w2.lo ^ w3.lo ^ const_add;

	assign p2 = permute_word(w2);
	assign p3 = permute_word(w3);

	assign w1_next    = permute_word(w1);
	assign w2_next.hi = p2.hi;
	assign w2_next.lo = lfsr2_bytes(p2.lo);
	assign w3_next.hi = p3.hi;
	assign w3_next.lo = lfsr3_bytes(p3.lo);

endmodule

// ===== rtl/skt_ctrl.sv =====
// Round sequencer: round counter, round-constant LFSR and the busy state.
module skt_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [skt_pkg::ROUND_W-1:0]  count,
	output logic                         busy,
	output skt_pkg::ctrl_t               ctrl
);
	import skt_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic               state_q;
	logic [ROUND_W-1:0] round_q;
	logic [ROUND_W-1:0] last_round_q;
	logic [RC_W-1:0]    rc_q;
	logic               last_round;

	assign last_round = (round_q == last_round_q);
	assign busy       = (state_q == ST_RUN);

	assign ctrl.run   = busy;
	assign ctrl.last  = last_round;
	assign ctrl.round = round_q;
	assign ctrl.rc    = rc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			round_q      <= '0;
			last_round_q <= '0;
			rc_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// A run of zero rounds gives nothing and leaves the block idle.
					if (accept && (count != '0)) begin
						state_q      <= ST_RUN;
						round_q      <= '0;
						last_round_q <= count - ROUND_W'(1);
						rc_q         <= RC_FIRST;
					end
				end
				ST_RUN: begin
					round_q <= round_q + ROUND_W'(1);
					rc_q    <= step_constant(rc_q);
					if (last_round) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/skinny128_tweakey_schedule.sv =====
// Top level of the SKINNY-128 tweakey schedule: configuration, word state and result register.
// When start is taken the word state is loaded, and every round tweakey passes through the
// result register; one word follows in every cycle until the last round of the run.
// Busy is high while the shared round unit steps the state through the saturated round count,
// and the next word is taken once busy has fallen. A round count of zero yields no result and
// leaves the block idle, so a word can be taken in every cycle. The receiver cannot stall.
// Reset clears the sequencer and the result strobe and sets three words and 56 rounds.
module skinny128_tweakey_schedule (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  skt_pkg::in_t                     item,
	output logic                             result_valid,
	output skt_pkg::out_t                    result,
	input  logic                             cfg_we,
	input  logic [skt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [skt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import skt_pkg::*;

	// Configuration registers.
	logic [WORDS_W-1:0] tweakey_words_q;
	logic [ROUND_W-1:0] round_count_q;

	// Running tweakey words.
	tk_word_t w1_q;
	tk_word_t w2_q;
	tk_word_t w3_q;
	tk_word_t w1_next;
	tk_word_t w2_next;
	tk_word_t w3_next;

	logic [HALF_W-1:0]  round_tweakey;
	logic [ROUND_W-1:0] count_sat;
	logic               use_tk2;
	logic               use_tk3;
	logic               accept;
	ctrl_t              ctrl;

	out_t result_q;
	logic result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tweakey_words_q <= WORDS_RESET;
			round_count_q   <= MAX_ROUNDS_CODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TWEAKEY_WORDS: tweakey_words_q <= cfg_data[WORDS_W-1:0];
				REG_ROUND_COUNT:   round_count_q   <= cfg_data[ROUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A word count of zero behaves as TK1 alone, so only the counts two and three
	// bring in further words. Round counts above the maximum are clipped.
	assign use_tk2   = (tweakey_words_q >= 2'd2);
	assign use_tk3   = (tweakey_words_q == 2'd3);
	assign count_sat = (round_count_q > MAX_ROUNDS_CODE) ? MAX_ROUNDS_CODE : round_count_q;

	assign accept = start && !busy;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.count  (count_sat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	skt_round_unit u_round (
		.w1            (w1_q),
		.w2            (w2_q),
		.w3            (w3_q),
		.rc            (ctrl.rc),
		.w1_next       (w1_next),
		.w2_next       (w2_next),
		.w3_next       (w3_next),
		.round_tweakey (round_tweakey)
	);

	// The word state is loaded on a start and stepped once for every round issued.
	// Unused words are loaded as zero so that they drop out of the xor.
	always_ff @(posedge clk) begin
		if (accept) begin
			w1_q.lo <= item.tk1_low;
			w1_q.hi <= item.tk1_high;
			w2_q.lo <= use_tk2 ? item.tk2_low  : '0;
			w2_q.hi <= use_tk2 ? item.tk2_high : '0;
			w3_q.lo <= use_tk3 ? item.tk3_low  : '0;
			w3_q.hi <= use_tk3 ? item.tk3_high : '0;
		end else if (ctrl.run) begin
			w1_q <= w1_next;
			w2_q <= w2_next;
			w3_q <= w3_next;
		end
	end

	// The result register keeps the round unit apart from the output; a new start can be
	// taken while the final round tweakey of the previous run is still on the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctrl.run;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			result_q.round_tweakey <= round_tweakey;
			result_q.round_number  <= ctrl.round;
			result_q.last          <= ctrl.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== bench/tb_skinny128_tweakey_schedule.sv =====
// Self-checking testbench for the SKINNY-128 tweakey schedule block.
`timescale 1ns / 1ps

module tb_skinny128_tweakey_schedule;

	import skt_pkg::*;

	// If the watchdog sees this many cycles in a row with no word taken in and no result,
	// the block is taken to be hung. The longest quiet stretch in a correct run is made up of
	// the final settling wait and a string of random sender gaps.
	localparam int unsigned QUIET_LIMIT = 1000;

	// Cycles allowed for the block to settle once the last expected result has arrived.
	// The block is already idle by then, and a run with zero rounds produces no result at all.
	localparam int unsigned SETTLE_CYCLES = 4;

	// Cycles allowed after the final result.
	localparam int unsigned TAIL_CYCLES = 64;

	// Source cell for each destination cell of the permutation P, one nibble per cell.
	// Cell 0 is in the lowest nibble.
	localparam logic [63:0] CELL_SOURCE = 64'h76543210_BCEAD8F9;

	localparam logic [63:0] LANE_LSB = 64'h0101010101010101;
	localparam logic [63:0] LANE_MSB = 64'h8080808080808080;
	localparam logic [63:0] LANE_HI7 = 64'hfefefefefefefefe;
	localparam logic [63:0] LANE_LO7 = 64'h7f7f7f7f7f7f7f7f;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic                   busy;
	in_t                    item      = '0;
	logic                   result_valid;
	out_t                   result;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Our copy of the configuration, updated at the edge that writes the block's register.
	logic [WORDS_W-1:0] words_setting  = WORDS_RESET;
	logic [ROUND_W-1:0] rounds_setting = MAX_ROUNDS_CODE;

	// Round tweakeys still owed by the block, oldest first.
	out_t round_key_queue[$];

	// When set, the sender offers a new word in every cycle with no gaps.
	bit calm = 1'b0;

	int unsigned failures     = 0;
	int unsigned quiet_cycles = 0;

	skinny128_tweakey_schedule dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction of the tweakey schedule.
	// A 128-bit word is held as {high half, low half}, so byte k sits at bits 8k+7:8k and
	// rows 0 and 1 of the state are the low 64 bits.
	// ------------------------------------------------------------------

	// The cell permutation applied to every word between rounds.
	function automatic logic [127:0] permute_cells(input logic [127:0] w);
		logic [127:0] r;
		r = '0;
		for (int i = 0; i < 16; i++)
			r[8*i +: 8] = w[8*CELL_SOURCE[4*i +: 4] +: 8];
		return r;
	endfunction

	// LFSR2 on each byte of the top two rows: shift up, feed back bit 7 xor bit 5.
	function automatic logic [63:0] lfsr2_rows(input logic [63:0] x);
		return ((x << 1) & LANE_HI7) | (((x >> 7) ^ (x >> 5)) & LANE_LSB);
	endfunction

	// LFSR3 on each byte of the top two rows: shift down, feed back bit 0 xor bit 6.
	function automatic logic [63:0] lfsr3_rows(input logic [63:0] x);
		return ((x >> 1) & LANE_LO7) | (((x << 7) ^ (x << 1)) & LANE_MSB);
	endfunction

	// Works out every round tweakey that one accepted word will produce under the
	// present settings, and queues them in order.
	function automatic void schedule_tweakeys(input in_t w);
		logic [127:0]  k1;
		logic [127:0]  k2;
		logic [127:0]  k3;
		logic [5:0]    rc;
		logic          feedback;
		logic [63:0]   lane;
		out_t          want;
		int unsigned   words;
		int unsigned   rounds;
		// A word count of zero behaves as one, and counts past the maximum saturate.
		words  = (words_setting == '0) ? 1 : words_setting;
		rounds = (rounds_setting > MAX_ROUNDS) ? MAX_ROUNDS : rounds_setting;
		// Unused words are loaded as zero whatever the inputs carry.
		k1 = {w.tk1_high, w.tk1_low};
		k2 = (words >= 2) ? {w.tk2_high, w.tk2_low} : '0;
		k3 = (words >= 3) ? {w.tk3_high, w.tk3_low} : '0;
		rc = '0;
		for (int unsigned r = 0; r < rounds; r++) begin
			// The constant register steps before each round, so round 0 sees 0x01.
			feedback = ~(rc[5] ^ rc[4]);
			rc = {rc[4:0], feedback};
			lane = k1[63:0] ^ k2[63:0] ^ k3[63:0];
			lane[3:0]   = lane[3:0] ^ rc[3:0];
			lane[33:32] = lane[33:32] ^ rc[5:4];
			want.round_tweakey = lane;
			want.round_number  = ROUND_W'(r);
			want.last          = (r + 1 == rounds);
			round_key_queue.push_back(want);
			k1 = permute_cells(k1);
			k2 = permute_cells(k2);
			k3 = permute_cells(k3);
			k2[63:0] = lfsr2_rows(k2[63:0]);
			k3[63:0] = lfsr3_rows(k3[63:0]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checking and the watchdog.
	// Outputs are sampled at the rising edge, before the block's own updates land, so each
	// result is compared with the oldest expectation in the cycle that it is shown.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy)
				quiet_cycles = 0;
			if (result_valid) begin
				quiet_cycles = 0;
				if (round_key_queue.size() == 0) begin
					$error("unexpected result word: round_tweakey %h round_number %0d last %b",
						result.round_tweakey, result.round_number, result.last);
					failures++;
				end else begin
					want = round_key_queue.pop_front();
					if (result.round_tweakey !== want.round_tweakey) begin
						$error("round_tweakey: expected %h, got %h",
							want.round_tweakey, result.round_tweakey);
						failures++;
					end
					if (result.round_number !== want.round_number) begin
						$error("round_number: expected %0d, got %0d",
							want.round_number, result.round_number);
						failures++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, result.last);
						failures++;
					end
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Offers one word until the block takes it. Outside calm stretches the sender drops
	// start in about a fifth of the cycles at random, busy or not, so that the gaps land
	// on every phase of a run. Start is left as it is once the word has gone, so the next
	// word can follow in the very next cycle.
	task automatic send_word(input in_t w);
		logic offer;
		item <= w;
		forever begin
			offer = calm || ($urandom_range(0, 99) >= 22);
			start <= offer;
			@(posedge clk);
			if (offer && !busy)
				break;
		end
		schedule_tweakeys(w);
	endtask

	// Holds the sender off until every owed round tweakey has arrived and the block is idle.
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (round_key_queue.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; the write enable is left high for the caller to lower.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		case (index)
			REG_TWEAKEY_WORDS: words_setting  = data[WORDS_W-1:0];
			REG_ROUND_COUNT:   rounds_setting = data[ROUND_W-1:0];
			default: ;
		endcase
	endtask

	// Waits for the block to go idle and then writes both registers. The raw data goes
	// to the port, so upper bits of the word count are exercised as well.
	task automatic configure(input logic [CFG_DATA_W-1:0] words_data,
			input logic [CFG_DATA_W-1:0] rounds_data);
		wait_for_drain();
		write_register(REG_TWEAKEY_WORDS, words_data);
		write_register(REG_ROUND_COUNT, rounds_data);
		cfg_we <= 1'b0;
	endtask

	// Mostly uniform halves, with a share of all-zero, all-one and single-bit halves.
	function automatic logic [63:0] random_half();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_t random_word();
		in_t w;
		w.tk1_low  = random_half();
		w.tk1_high = random_half();
		w.tk2_low  = random_half();
		w.tk2_high = random_half();
		w.tk3_low  = random_half();
		w.tk3_high = random_half();
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// The settings left by reset: all three words and 56 rounds, with extreme patterns.
	task automatic test_default_settings();
		in_t w;
		send_word('0);
		send_word('1);
		send_word({6{64'h8080808001010101}});
		w.tk1_low  = 64'h0706050403020100;
		w.tk1_high = 64'h0f0e0d0c0b0a0908;
		w.tk2_low  = 64'h7f7f7f7f7f7f7f7f;
		w.tk2_high = 64'hfdffffffffffffff;
		w.tk3_low  = 64'h0123456789abcdef;
		w.tk3_high = 64'hfedcba9876543210;
		send_word(w);
	endtask

	// Each word count, with all-one inputs so that any leak from an unused word shows.
	// A count of zero must act as one, and the upper data bits must be ignored.
	task automatic test_word_counts();
		configure(6'h3c, 6'd40);
		send_word('1);
		configure(6'd1, 6'd40);
		send_word('1);
		configure(6'd2, 6'd40);
		send_word('1);
		send_word(random_word());
		configure(6'h3f, 6'd40);
		send_word('1);
	endtask

	// Round counts at their edges: none, one, two, the standard lengths 48 and 56, and
	// counts past the maximum that must saturate.
	task automatic test_round_counts();
		configure(6'd3, 6'd0);
		send_word(random_word());
		send_word(random_word());
		configure(6'd3, 6'd1);
		send_word(random_word());
		configure(6'd2, 6'd2);
		send_word(random_word());
		configure(6'd3, 6'd48);
		send_word(random_word());
		configure(6'd1, 6'd57);
		send_word(random_word());
		configure(6'd3, 6'd63);
		send_word(random_word());
		configure(6'd3, 6'd56);
		send_word(random_word());
	endtask

	// A long stretch with start held high throughout, so each new word is taken the
	// moment busy falls, with short runs to keep the block turning round often.
	task automatic test_unbroken_stream();
		configure(6'd3, 6'd3);
		calm = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(random_word());
		calm = 1'b0;
	endtask

	// The sender stops until every owed result has come, then carries on.
	task automatic test_drain_pause();
		configure(6'd2, 6'd5);
		for (int i = 0; i < 6; i++)
			send_word(random_word());
		wait_for_drain();
		for (int i = 0; i < 6; i++)
			send_word(random_word());
	endtask

	// Phases of random words, each under its own random settings. Most runs are short,
	// with a share of the standard lengths, the odd empty run and saturating counts.
	task automatic test_random_settings();
		logic [CFG_DATA_W-1:0] rounds_data;
		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(0, 9))
				0:       rounds_data = 6'd0;
				6:       rounds_data = 6'd40;
				7:       rounds_data = 6'd48;
				8:       rounds_data = 6'd56;
				9:       rounds_data = CFG_DATA_W'($urandom_range(0, 63));
				default: rounds_data = CFG_DATA_W'($urandom_range(1, 8));
			endcase
			configure(CFG_DATA_W'($urandom_range(0, 63)), rounds_data);
			for (int i = 0; i < 30; i++)
				send_word(random_word());
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run.
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_default_settings();
		test_word_counts();
		test_round_counts();
		test_unbroken_stream();
		test_drain_pause();
		test_random_settings();
		start <= 1'b0;
		// The watchdog ends the run if the owed results never come.
		while (round_key_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
